@@ sv/spr_pkg.sv @@
// Shared types, constants and codes for the sorted parent route table.
package spr_pkg;

   localparam int unsigned DEPTH_DEFAULT      = 4;
   localparam int unsigned PATH_BYTES_DEFAULT = 8;
   localparam int unsigned POS_W              = 5;
   localparam int unsigned MAC_W              = 48;
   localparam int unsigned COST_W             = 16;
   localparam int unsigned TIME_W             = 32;
   localparam int unsigned PATH_W             = 64;
   localparam int unsigned LEN_W              = 4;
   localparam int unsigned OCC_W              = 3;

   localparam logic [COST_W-1:0] NO_ROUTE_COST   = 16'd15984;
   localparam logic [TIME_W-1:0] TIMEOUT_RESET   = 32'd30000;

   typedef enum logic [1:0] {
      CMD_UPDATE = 2'd0,
      CMD_PURGE  = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      TBL_HOLD,
      TBL_DROP,
      TBL_INSERT,
      TBL_CLEAR
   } tbl_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MATCH,
      ST_RANK,
      ST_DROP,
      ST_INSERT,
      ST_PURGE,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [MAC_W-1:0]    peer_mac;
      logic [COST_W-1:0]   link_cost;
      logic [PATH_W-1:0]   route_path;
      logic [LEN_W-1:0]    route_len;
      logic [1:0]          entry_index;
      logic [TIME_W-1:0]   now_time;
   } req_type;

   typedef struct packed {
      logic                has_route;
      logic [MAC_W-1:0]    next_hop_mac;
      logic [COST_W-1:0]   route_cost;
      logic [PATH_W-1:0]   primary_path;
      logic [LEN_W-1:0]    primary_path_len;
      logic [OCC_W-1:0]    occupancy;
      logic                rejected;
   } rsp_type;

   typedef struct packed {
      logic [MAC_W-1:0]    mac;
      logic [COST_W-1:0]   cost;
      logic [TIME_W-1:0]   seen;
      logic [PATH_W-1:0]   path;
      logic [LEN_W-1:0]    len;
   } entry_type;

   typedef struct packed {
      tbl_kind_type        kind;
      logic [POS_W-1:0]    pos;
   } tbl_op_type;

endpackage

@@ sv/spr_table.sv @@
// Candidate storage: a row of entry cells that shift to drop or insert one entry.
module spr_table #(
   parameter int unsigned TABLE_DEPTH = spr_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spr_pkg::tbl_op_type             op,
   input  spr_pkg::entry_type              new_entry,
   input  logic [spr_pkg::POS_W-1:0]       rd_ptr,
   output spr_pkg::entry_type              rd_entry,
   output spr_pkg::entry_type              head_entry,
   output logic [spr_pkg::COST_W-1:0]      tail_cost,
   output logic [spr_pkg::POS_W-1:0]       count
);

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   spr_pkg::entry_type entry_ff [TABLE_DEPTH];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      spr_pkg::entry_type up_w;
      spr_pkg::entry_type dn_w;
      spr_pkg::entry_type cell_in;

      if (g + 1 < TABLE_DEPTH) begin : g_up
         assign up_w = entry_ff[g+1];
      end else begin : g_up_last
         assign up_w = entry_ff[g];
      end

      if (g > 0) begin : g_dn
         assign dn_w = entry_ff[g-1];
      end else begin : g_dn_first
         assign dn_w = entry_ff[g];
      end

      always_comb begin
         cell_in = entry_ff[g];
         unique case (op.kind)
            spr_pkg::TBL_DROP: begin
               if (spr_pkg::POS_W'(g) >= op.pos) begin
                  cell_in = up_w;
               end
            end
            spr_pkg::TBL_INSERT: begin
               if (spr_pkg::POS_W'(g) > op.pos) begin
                  cell_in = dn_w;
               end else if (spr_pkg::POS_W'(g) == op.pos) begin
                  cell_in = new_entry;
               end
            end
            spr_pkg::TBL_HOLD,
            spr_pkg::TBL_CLEAR: begin
               cell_in = entry_ff[g];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         entry_ff[g] <= cell_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      unique case (op.kind)
         spr_pkg::TBL_DROP:   count_in = count_ff - CNT_W'(1);
         spr_pkg::TBL_INSERT: count_in = count_ff + CNT_W'(1);
         spr_pkg::TBL_CLEAR:  count_in = '0;
         spr_pkg::TBL_HOLD:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rd_entry   = entry_ff[rd_ptr[IDX_W-1:0]];
   assign head_entry = entry_ff[0];
   assign tail_cost  = entry_ff[TABLE_DEPTH-1].cost;
   assign count      = spr_pkg::POS_W'(count_ff);

endmodule

@@ sv/spr_ctrl.sv @@
// Command sequencer with the shared compare unit walking the table one entry a cycle.
module spr_ctrl #(
   parameter int unsigned TABLE_DEPTH = spr_pkg::DEPTH_DEFAULT,
   parameter int unsigned PATH_BYTES  = spr_pkg::PATH_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  spr_pkg::req_type                req,
   output logic                            busy,
   input  logic [spr_pkg::TIME_W-1:0]      timeout,
   output spr_pkg::tbl_op_type             op,
   output spr_pkg::entry_type              new_entry,
   output logic [spr_pkg::POS_W-1:0]       rd_ptr,
   input  spr_pkg::entry_type              rd_entry,
   input  spr_pkg::entry_type              head_entry,
   input  logic [spr_pkg::COST_W-1:0]      tail_cost,
   input  logic [spr_pkg::POS_W-1:0]       count,
   output logic                            rsp_valid,
   output spr_pkg::rsp_type                rsp
);

   localparam logic [spr_pkg::POS_W-1:0] DEPTH_POS = spr_pkg::POS_W'(TABLE_DEPTH);
   localparam logic [spr_pkg::POS_W-1:0] LAST_POS  = spr_pkg::POS_W'(TABLE_DEPTH - 1);
   localparam logic [spr_pkg::LEN_W-1:0] MAX_LEN   = spr_pkg::LEN_W'(PATH_BYTES);

   spr_pkg::state_type              state_ff, state_in;
   logic [spr_pkg::POS_W-1:0]       ptr_ff, ptr_in;
   logic [spr_pkg::POS_W-1:0]       rank_ff, rank_in;
   logic [spr_pkg::POS_W-1:0]       drop_pos_ff, drop_pos_in;
   logic [spr_pkg::POS_W-1:0]       end_ff, end_in;
   logic                            found_ff, found_in;
   logic                            has_drop_ff, has_drop_in;
   logic                            rej_ff, rej_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   spr_pkg::req_type                req_ff, req_in;
   spr_pkg::entry_type              new_ff, new_in;
   spr_pkg::rsp_type                rsp_ff, rsp_in;

   logic [spr_pkg::LEN_W-1:0]       len_sat;
   logic [spr_pkg::PATH_W-1:0]      path_kept;
   logic [spr_pkg::TIME_W-1:0]      age;
   logic                            mac_eq, cost_lt, cost_eq, aged, beats_tail;
   logic                            scan_done, precede, skip;

   // incoming path trimmed to its length
   always_comb begin
      len_sat = (req.route_len > MAX_LEN) ? MAX_LEN : req.route_len;
      for (int b = 0; b < spr_pkg::PATH_W / 8; b++) begin
         path_kept[b*8 +: 8] = (spr_pkg::LEN_W'(b) < len_sat) ? req.route_path[b*8 +: 8] : 8'h00;
      end
   end

   // shared compare unit on the entry under the pointer
   assign age        = req_ff.now_time - rd_entry.seen;
   assign mac_eq     = rd_entry.mac == new_ff.mac;
   assign cost_lt    = rd_entry.cost < new_ff.cost;
   assign cost_eq    = rd_entry.cost == new_ff.cost;
   assign aged       = age >= timeout;
   assign beats_tail = new_ff.cost < tail_cost;
   assign scan_done  = ptr_ff >= count;
   assign skip       = found_ff && (ptr_ff == drop_pos_ff);
   assign precede    = cost_lt || (cost_eq && (!found_ff || (ptr_ff < drop_pos_ff)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spr_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req.cmd)
                  spr_pkg::CMD_UPDATE: state_in = spr_pkg::ST_MATCH;
                  spr_pkg::CMD_PURGE:  state_in = spr_pkg::ST_PURGE;
                  spr_pkg::CMD_REMOVE: begin
                     state_in = (spr_pkg::POS_W'(req.entry_index) < count) ?
                                spr_pkg::ST_DROP : spr_pkg::ST_DONE;
                  end
                  spr_pkg::CMD_CLEAR:  state_in = spr_pkg::ST_CLEAR;
               endcase
            end
         end
         spr_pkg::ST_MATCH: begin
            if (scan_done) begin
               state_in = ((count < DEPTH_POS) || beats_tail) ?
                          spr_pkg::ST_RANK : spr_pkg::ST_DONE;
            end else if (mac_eq) begin
               state_in = spr_pkg::ST_RANK;
            end
         end
         spr_pkg::ST_RANK: begin
            if (ptr_ff >= end_ff) begin
               state_in = has_drop_ff ? spr_pkg::ST_DROP : spr_pkg::ST_INSERT;
            end
         end
         spr_pkg::ST_DROP: begin
            state_in = (req_ff.cmd == spr_pkg::CMD_UPDATE) ?
                       spr_pkg::ST_INSERT : spr_pkg::ST_DONE;
         end
         spr_pkg::ST_INSERT: state_in = spr_pkg::ST_DONE;
         spr_pkg::ST_PURGE: begin
            if (scan_done) begin
               state_in = spr_pkg::ST_DONE;
            end
         end
         spr_pkg::ST_CLEAR: state_in = spr_pkg::ST_DONE;
         spr_pkg::ST_DONE:  state_in = spr_pkg::ST_IDLE;
      endcase
   end

   // working registers
   always_comb begin
      ptr_in      = ptr_ff;
      rank_in     = rank_ff;
      drop_pos_in = drop_pos_ff;
      end_in      = end_ff;
      found_in    = found_ff;
      has_drop_in = has_drop_ff;
      rej_in      = rej_ff;
      req_in      = req_ff;
      new_in      = new_ff;
      unique case (state_ff)
         spr_pkg::ST_IDLE: begin
            if (start) begin
               req_in      = req;
               new_in.mac  = req.peer_mac;
               new_in.cost = req.link_cost;
               new_in.seen = req.now_time;
               new_in.path = path_kept;
               new_in.len  = len_sat;
               ptr_in      = '0;
               rank_in     = '0;
               found_in    = 1'b0;
               has_drop_in = 1'b0;
               rej_in      = 1'b0;
               end_in      = '0;
               drop_pos_in = spr_pkg::POS_W'(req.entry_index);
            end
         end
         spr_pkg::ST_MATCH: begin
            if (scan_done) begin
               ptr_in = '0;
               if (count < DEPTH_POS) begin
                  end_in = count;
               end else if (beats_tail) begin
                  has_drop_in = 1'b1;
                  drop_pos_in = LAST_POS;
                  end_in      = LAST_POS;
               end else begin
                  rej_in = 1'b1;
               end
            end else if (mac_eq) begin
               found_in    = 1'b1;
               has_drop_in = 1'b1;
               drop_pos_in = ptr_ff;
               end_in      = count;
               ptr_in      = '0;
            end else begin
               ptr_in = ptr_ff + spr_pkg::POS_W'(1);
            end
         end
         spr_pkg::ST_RANK: begin
            if (ptr_ff < end_ff) begin
               if (precede && !skip) begin
                  rank_in = rank_ff + spr_pkg::POS_W'(1);
               end
               ptr_in = ptr_ff + spr_pkg::POS_W'(1);
            end
         end
         spr_pkg::ST_PURGE: begin
            if (!scan_done && !aged) begin
               ptr_in = ptr_ff + spr_pkg::POS_W'(1);
            end
         end
         spr_pkg::ST_DROP,
         spr_pkg::ST_INSERT,
         spr_pkg::ST_CLEAR,
         spr_pkg::ST_DONE: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      op.kind      = spr_pkg::TBL_HOLD;
      op.pos       = '0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         spr_pkg::ST_DROP: begin
            op.kind = spr_pkg::TBL_DROP;
            op.pos  = drop_pos_ff;
         end
         spr_pkg::ST_INSERT: begin
            op.kind = spr_pkg::TBL_INSERT;
            op.pos  = rank_ff;
         end
         spr_pkg::ST_PURGE: begin
            if (!scan_done && aged) begin
               op.kind = spr_pkg::TBL_DROP;
               op.pos  = ptr_ff;
            end
         end
         spr_pkg::ST_CLEAR: op.kind = spr_pkg::TBL_CLEAR;
         spr_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (count != '0) begin
               rsp_in.has_route        = 1'b1;
               rsp_in.next_hop_mac     = head_entry.mac;
               rsp_in.route_cost       = head_entry.cost;
               rsp_in.primary_path     = head_entry.path;
               rsp_in.primary_path_len = head_entry.len;
            end else begin
               rsp_in.has_route        = 1'b0;
               rsp_in.next_hop_mac     = '0;
               rsp_in.route_cost       = spr_pkg::NO_ROUTE_COST;
               rsp_in.primary_path     = '0;
               rsp_in.primary_path_len = '0;
            end
            rsp_in.occupancy = count[spr_pkg::OCC_W-1:0];
            rsp_in.rejected  = rej_ff;
         end
         spr_pkg::ST_IDLE,
         spr_pkg::ST_MATCH,
         spr_pkg::ST_RANK: begin
            op.kind = spr_pkg::TBL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         rank_ff      <= '0;
         drop_pos_ff  <= '0;
         end_ff       <= '0;
         found_ff     <= 1'b0;
         has_drop_ff  <= 1'b0;
         rej_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         rank_ff      <= rank_in;
         drop_pos_ff  <= drop_pos_in;
         end_ff       <= end_in;
         found_ff     <= found_in;
         has_drop_ff  <= has_drop_in;
         rej_ff       <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      new_ff <= new_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = state_ff != spr_pkg::ST_IDLE;
   assign new_entry = new_ff;
   assign rd_ptr    = ptr_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ sv/sorted_parent_route_table.sv @@
// Top level of the sorted parent route table: sequencer, entry row and timeout register.
// An update walks the table in the match then the rank state, then drops (on a match or when
// the table is full), inserts and finishes; a rejected update walks, a purge walks dropping
// aged entries, and both then finish; remove drops and finishes, or just finishes when out of
// range; clear clears and finishes. One command at a time: busy is high until the result cycle.
// Reset: synchronous, active high; empties the table, timeout 30000. Results cannot be stalled.
module sorted_parent_route_table #(
   parameter int unsigned TABLE_DEPTH = spr_pkg::DEPTH_DEFAULT,
   parameter int unsigned PATH_BYTES  = spr_pkg::PATH_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  spr_pkg::req_type                req,
   output logic                            rsp_valid,
   output spr_pkg::rsp_type                rsp,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spr_pkg::TIME_W-1:0]      csr_data
);

   logic [spr_pkg::TIME_W-1:0]   timeout_ff;
   logic [spr_pkg::TIME_W-1:0]   timeout_in;
   spr_pkg::tbl_op_type          op;
   spr_pkg::entry_type           new_entry;
   spr_pkg::entry_type           rd_entry;
   spr_pkg::entry_type           head_entry;
   logic [spr_pkg::POS_W-1:0]    rd_ptr;
   logic [spr_pkg::POS_W-1:0]    count;
   logic [spr_pkg::COST_W-1:0]   tail_cost;

   assign csr_ready  = !busy;
   assign timeout_in = (csr_valid && csr_ready) ? csr_data : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= spr_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   spr_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PATH_BYTES  (PATH_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req),
      .busy       (busy),
      .timeout    (timeout_ff),
      .op         (op),
      .new_entry  (new_entry),
      .rd_ptr     (rd_ptr),
      .rd_entry   (rd_entry),
      .head_entry (head_entry),
      .tail_cost  (tail_cost),
      .count      (count),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   spr_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .new_entry  (new_entry),
      .rd_ptr     (rd_ptr),
      .rd_entry   (rd_entry),
      .head_entry (head_entry),
      .tail_cost  (tail_cost),
      .count      (count)
   );

endmodule
